FILE: hdl/sta_alloc_pkg.sv
`default_nettype none

package sta_alloc_pkg;

    // Default build values
    localparam int NUM_HANDLES_DEF  = 16;
    localparam int PAGE_BYTES_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 10;

    // Field widths
    localparam int OP_W      = 2;
    localparam int HANDLE_W  = 4;
    localparam int SIZE_W    = 16;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int ADDR_W    = 16;
    localparam int MEMSIZE_W = 17;
    localparam int END_W     = 17;
    localparam int CFG_IDX_W = 2;

    // Packed stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_FORMAT = 2'd0;
    localparam logic [OP_W-1:0] OP_CREATE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;
    localparam logic [OP_W-1:0] OP_TEST   = 2'd3;

    // Area kinds
    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHECKSUM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SELF     = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BYTES = 2'd1;

    // Register reset values
    localparam logic [ADDR_W-1:0]    BASE_ADDRESS_RST = 16'd64;
    localparam logic [MEMSIZE_W-1:0] MEMORY_BYTES_RST = 17'd65536;

    // One directory entry
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] bytes;
        logic [KIND_W-1:0] kind;
    } entry_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DIV,
        ST_MUL,
        ST_PASS_END,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

FILE: hdl/storage_area_table_allocator.sv
`default_nettype none

// Storage area directory allocator.
// Input channel s_*: one command item per handshake (op in s_tuser; handle, size and type
// in s_tdata). Result channel m_*: one item per command (status in m_tuser, address in
// m_tdata). Configuration channel cfg_*: writes base_address (index 0) or memory_bytes
// (index 1); other indexes are dropped. cfg_ready is always high.
// Format and bad-handle, bad-type check or create, or oversize commands go straight to
// the response state; check and test first pass through a lookup state that reads the entry.
// Create scans the directory in passes; each pass reads and compares every entry in turn
// and ends in a pass-end check, and each overlap found adds a divide and a multiply step,
// set by the single directory read port and the shared page-round unit (reciprocal multiply,
// then multiply back by the page size). The search needs at most NUM_HANDLES+1 passes.
// Only one command is in work at a time. s_tready is high only while the sequencer is
// idle; it rises at the edge that loads the result register, so the next command is
// taken at the following edge at the earliest.
// If the receiver stalls, the sequencer holds the next result until the register frees.
// Reset (aresetn low, synchronous) empties the directory through per-entry valid flags,
// restores both configuration registers and drops any pending result.
module storage_area_table_allocator #(
    parameter int NUM_HANDLES  = sta_alloc_pkg::NUM_HANDLES_DEF,
    parameter int PAGE_BYTES   = sta_alloc_pkg::PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = sta_alloc_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Command items
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // s_tdata: handle [3:0], area_size [19:4], area_type [21:20], zero [23:22]
    input  wire logic [sta_alloc_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: op [1:0]
    input  wire logic [sta_alloc_pkg::OP_W-1:0]        s_tuser,
    // Result items
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // m_tdata: area_address [15:0]
    output logic [sta_alloc_pkg::M_TDATA_W-1:0]        m_tdata,
    // m_tuser: status [1:0]
    output logic [sta_alloc_pkg::STATUS_W-1:0]         m_tuser,
    // Configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [sta_alloc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sta_alloc_pkg::MEMSIZE_W-1:0]   cfg_data
);
    import sta_alloc_pkg::*;

    localparam int IDX_W       = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
    localparam int NEED_W      = SIZE_W + 1;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int RECIP_SHIFT = END_W + PAGE_SHIFT;
    localparam int RECIP_W     = END_W + 2;
    localparam int PROD_W      = END_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_HANDLES - 1);

    // Directory storage and valid flags
    entry_t                   mem [NUM_HANDLES];
    entry_t                   mem_q_reg;
    logic                     rd_valid_reg;
    logic [NUM_HANDLES-1:0]   valid_reg, valid_next;
    logic [IDX_W-1:0]         rd_addr;
    logic                     mem_we;

    // Sequencer and work registers
    state_t                   state_reg, state_next;
    logic [OP_W-1:0]          op_reg, op_next;
    logic [IDX_W-1:0]         hidx_reg, hidx_next;
    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic [NEED_W-1:0]        need_reg, need_next;
    logic [ADDR_W-1:0]        lo_reg, lo_next;
    logic                     moved_reg, moved_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [END_W-1:0]         end_reg, end_next;
    logic [END_W-1:0]         quot_reg, quot_next;
    logic [STATUS_W-1:0]      res_status_reg, res_status_next;
    logic [ADDR_W-1:0]        res_addr_reg, res_addr_next;

    // Configuration and output registers
    logic [ADDR_W-1:0]        base_reg;
    logic [MEMSIZE_W-1:0]     mem_bytes_reg;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0]      m_status_reg, m_status_next;
    logic [ADDR_W-1:0]        m_addr_reg, m_addr_next;

    // Unpacked command fields
    logic [HANDLE_W-1:0]      in_handle;
    logic [SIZE_W-1:0]        in_size;
    logic [KIND_W-1:0]        in_kind;
    logic                     in_handle_ok;
    logic                     in_kind_ok;
    logic [NEED_W-1:0]        in_need;

    // Entry as seen through its valid flag
    logic [ADDR_W-1:0]        ent_start;
    logic [SIZE_W-1:0]        ent_bytes;
    logic [KIND_W-1:0]        ent_kind;
    logic [END_W-1:0]         ent_end;
    logic [END_W-1:0]         cand_lo;
    logic [END_W-1:0]         cand_hi;
    logic [END_W-1:0]         ent_start_w;
    logic                     touch;
    logic [PROD_W-1:0]        recip_prod;
    logic [31:0]              page_next;
    logic [END_W-1:0]         span_end;

    assign in_handle    = s_tdata[3:0];
    assign in_size      = s_tdata[19:4];
    assign in_kind      = s_tdata[21:20];
    assign in_handle_ok = (32'(in_handle) < NUM_HANDLES);
    assign in_kind_ok   = (in_kind == KIND_CHECKSUM) || (in_kind == KIND_SELF);
    assign in_need      = (in_kind == KIND_CHECKSUM) ?
                          NEED_W'(in_size) + NEED_W'(HEADER_BYTES) : NEED_W'(in_size);

    assign ent_start   = rd_valid_reg ? mem_q_reg.start : '0;
    assign ent_bytes   = rd_valid_reg ? mem_q_reg.bytes : '0;
    assign ent_kind    = rd_valid_reg ? mem_q_reg.kind  : KIND_NONE;
    assign ent_start_w = END_W'(ent_start);
    assign ent_end     = END_W'(ent_start) + END_W'(ent_bytes);
    assign cand_lo     = END_W'(lo_reg);
    assign cand_hi     = END_W'(lo_reg) + END_W'(need_reg[SIZE_W-1:0]);
    assign span_end    = END_W'(lo_reg) + END_W'(need_reg[SIZE_W-1:0]);

    // Inclusive overlap test against the candidate range
    assign touch = rd_valid_reg && (ent_kind != KIND_NONE) &&
                   (((ent_start_w <= cand_lo) && (ent_end >= cand_lo)) ||
                    ((ent_start_w <= cand_hi) && (ent_end >= cand_hi)) ||
                    ((ent_start_w >= cand_lo) && (ent_start_w <= cand_hi)));

    // Shared page-round unit: divide by reciprocal, then multiply back
    assign recip_prod = PROD_W'(end_reg) * PROD_W'(RECIP);
    assign page_next  = (32'(quot_reg) + 32'd1) * 32'(PAGE_BYTES);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_addr_reg;
    assign m_tuser   = m_status_reg;

    // Next state and datapath control
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        hidx_next       = hidx_reg;
        kind_next       = kind_reg;
        need_next       = need_reg;
        lo_next         = lo_reg;
        moved_next      = moved_reg;
        idx_next        = idx_reg;
        end_next        = end_reg;
        quot_next       = quot_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        valid_next      = valid_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        rd_addr         = idx_reg;
        mem_we          = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                rd_addr = IDX_W'(in_handle);
                if (s_tvalid) begin
                    op_next         = s_tuser;
                    hidx_next       = IDX_W'(in_handle);
                    kind_next       = in_kind;
                    need_next       = in_need;
                    res_addr_next   = '0;
                    res_status_next = STAT_OK;
                    lo_next         = base_reg;
                    moved_next      = 1'b0;
                    idx_next        = '0;
                    if (s_tuser == OP_FORMAT) begin
                        valid_next = '0;
                        state_next = ST_RESP;
                    end else if (!in_handle_ok) begin
                        res_status_next = STAT_INVALID;
                        state_next      = ST_RESP;
                    end else if (s_tuser == OP_TEST) begin
                        state_next = ST_LOOKUP;
                    end else if (!in_kind_ok) begin
                        res_status_next = STAT_INVALID;
                        state_next      = ST_RESP;
                    end else if (s_tuser == OP_CHECK) begin
                        state_next = ST_LOOKUP;
                    end else if (in_need[SIZE_W]) begin
                        res_status_next = STAT_NO_SPACE;
                        state_next      = ST_RESP;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end

            ST_LOOKUP: begin
                if (op_reg == OP_CHECK) begin
                    if ((ent_start == '0) || (ent_kind != kind_reg) ||
                        (NEED_W'(ent_bytes) != need_reg)) begin
                        res_status_next = STAT_MISMATCH;
                    end else begin
                        res_addr_next = ent_start;
                    end
                end else begin
                    if ((ent_start == '0) || (ent_kind == KIND_NONE) || (ent_bytes == '0)) begin
                        res_status_next = STAT_MISMATCH;
                    end else begin
                        res_addr_next = ent_start;
                    end
                end
                state_next = ST_RESP;
            end

            ST_SCAN_RD: begin
                rd_addr    = idx_reg;
                state_next = ST_SCAN_CMP;
            end

            ST_SCAN_CMP: begin
                if (touch) begin
                    end_next   = ent_end;
                    state_next = ST_DIV;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = ST_PASS_END;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end

            ST_DIV: begin
                quot_next  = END_W'(recip_prod >> RECIP_SHIFT);
                state_next = ST_MUL;
            end

            ST_MUL: begin
                if (page_next > 32'h0000_FFFF) begin
                    res_status_next = STAT_NO_SPACE;
                    state_next      = ST_RESP;
                end else begin
                    lo_next    = page_next[ADDR_W-1:0];
                    moved_next = 1'b1;
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_PASS_END;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN_RD;
                    end
                end
            end

            ST_PASS_END: begin
                if (span_end > mem_bytes_reg) begin
                    res_status_next = STAT_NO_SPACE;
                    state_next      = ST_RESP;
                end else if (moved_reg) begin
                    moved_next = 1'b0;
                    idx_next   = '0;
                    state_next = ST_SCAN_RD;
                end else if (lo_reg == '0) begin
                    res_status_next = STAT_NO_SPACE;
                    state_next      = ST_RESP;
                end else begin
                    mem_we               = 1'b1;
                    valid_next[hidx_reg] = 1'b1;
                    res_addr_next        = lo_reg;
                    state_next           = ST_RESP;
                end
            end

            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register and control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Work and result payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        hidx_reg       <= hidx_next;
        kind_reg       <= kind_next;
        need_reg       <= need_next;
        lo_reg         <= lo_next;
        moved_reg      <= moved_next;
        idx_reg        <= idx_next;
        end_reg        <= end_next;
        quot_reg       <= quot_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= BASE_ADDRESS_RST;
            mem_bytes_reg <= MEMORY_BYTES_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS: base_reg      <= cfg_data[ADDR_W-1:0];
                CFG_MEMORY_BYTES: mem_bytes_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Directory memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[hidx_reg] <= '{start: lo_reg, bytes: need_reg[SIZE_W-1:0], kind: kind_reg};
        end
        mem_q_reg    <= mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    // A command moves the sequencer out of idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("command accepted but sequencer stayed idle");

    // A new result appears only from the response state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg)) |-> ($past(state_reg) == ST_RESP))
        else $error("result raised outside response state");

    // Only a found, nonzero range that fits is recorded
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ((lo_reg != '0) && (span_end <= mem_bytes_reg) && !moved_reg))
        else $error("directory written with an unusable range");

    // Failures carry address zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_status_reg != STAT_OK)) |-> (m_addr_reg == '0))
        else $error("failed result carries an address");

endmodule

`default_nettype wire
